FILE: sv/mpm_pkg.sv
// Shared constants, codes and the cell control struct for the modular
// polynomial multiplier. No dependencies.
package mpm_pkg;

  localparam int CW      = 31;                 // coefficient width
  localparam int MAX_LEN = 32;                 // coefficients per factor
  localparam logic [63:0] MODULUS = 64'd998244353;

  localparam int LW  = $clog2(MAX_LEN + 1);    // factor length
  localparam int NW  = $clog2(2 * MAX_LEN);    // product index
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TW  = CW + 2;                 // 2r + b, below 3M
  localparam int BCW = $clog2(CW);

  // Shift-and-subtract steps that bring any CW-bit value below MODULUS.
  localparam int RED_STEPS = $clog2(((64'd1 << CW) + MODULUS - 64'd1) / MODULUS);
  localparam int RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  localparam logic [1:0] KIND_FIRST    = 2'd0;
  localparam logic [1:0] KIND_SECOND   = 2'd1;
  localparam logic [1:0] KIND_MULTIPLY = 2'd2;

  typedef struct packed {
    logic clear;     // zero the running sums
    logic step;      // one double-and-add step of the modular multiply
    logic first;     // first step: partial product starts at zero
    logic bit_val;   // multiplier bit, MSB first
    logic accum;     // shift sums one cell down, adding the product
    logic use_prod;  // product is real (not a padding step)
  } mpm_ctl_t;

endpackage

FILE: sv/mpm_cell.sv
// One cell of the transposed convolution chain: holds one second-factor
// coefficient, a bit-serial modular product and a running sum.
// Depends on mpm_pkg.
module mpm_cell
  import mpm_pkg::*;
(
  input  logic            clk,
  input  mpm_ctl_t        ctl,
  input  logic            load,
  input  logic            active,
  input  logic [CW-1:0]   load_value,
  input  logic [CW-1:0]   s_in,
  output logic [CW-1:0]   s_out
);

  localparam logic [TW-1:0] MOD_T  = TW'(MODULUS);
  localparam logic [TW-1:0] MOD2_T = TW'(MODULUS << 1);
  localparam logic [CW:0]   MOD_S  = (CW + 1)'(MODULUS);

  logic [CW-1:0] b;
  logic [CW-1:0] r;
  logic [CW-1:0] s;
  logic [CW-1:0] r_base;
  logic [TW-1:0] t;
  logic [CW-1:0] r_next;
  logic [CW-1:0] p;
  logic [CW:0]   sum;
  logic [CW-1:0] s_next;

  always_comb begin
    r_base = ctl.first ? '0 : r;
    t = {1'b0, r_base, 1'b0} + (ctl.bit_val ? {2'b00, b} : '0);
    priority if (t >= MOD2_T) begin
      r_next = CW'(t - MOD2_T);
    end else if (t >= MOD_T) begin
      r_next = CW'(t - MOD_T);
    end else begin
      r_next = CW'(t);
    end
    p = (ctl.use_prod && active) ? r : '0;
    sum = {1'b0, s_in} + {1'b0, p};
    s_next = (sum >= MOD_S) ? CW'(sum - MOD_S) : CW'(sum);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b <= load_value;
    end
    if (ctl.step) begin
      r <= r_next;
    end
    if (ctl.clear) begin
      s <= '0;
    end else if (ctl.accum) begin
      s <= s_next;
    end
  end

  assign s_out = s;

endmodule

FILE: sv/modular_polynomial_multiply_core.sv
// Top level of the modular polynomial multiplier: push reduction, first-factor
// store, sequencer and the chain of mpm_cell instances.
// Depends on mpm_pkg and mpm_cell.
//
//  channel  | signals                                 | dir
//  ---------+-----------------------------------------+-----
//  input    | in_valid, in_ready, kind, coefficient   | in
//  result   | out_valid, out_ready, product_coefficient, last | out
//
// A push runs the shift-subtract reduction of the incoming value, one step
// per cycle, and no new push is accepted until it is done.
// A multiply emits lenA+lenB-1 results; each of the first lenA goes through
// FETCH, the bit-serial multiply in the cells, ACC, EMIT; later ones skip MUL.
// Reset (rst, synchronous) empties both factors; stored values need none.
// A result waiting in the output register stalls the chain only when the
// next one is ready; input is held off until the last product coefficient
// has moved into the output register.
module modular_polynomial_multiply_core
  import mpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    kind,
  input  logic [CW-1:0] coefficient,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CW-1:0] product_coefficient,
  output logic          last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  state_t         state;
  logic [LW-1:0]  first_length;
  logic [LW-1:0]  second_length;
  logic [CW-1:0]  red_val;
  logic [RCW-1:0] red_cnt;
  logic           red_to_b;
  logic [BCW-1:0] bit_cnt;
  logic [CW-1:0]  x;
  logic [NW-1:0]  n;
  logic [NW-1:0]  total;
  logic [CW-1:0]  a_store [MAX_LEN];

  logic [CW-1:0]  red_div;
  logic [CW-1:0]  red_next;
  logic           commit;
  logic           in_xfer;
  logic           out_free;
  logic           emit_fire;
  logic           at_end;
  mpm_ctl_t       ctl;
  logic [CW-1:0]  s_chain [MAX_LEN+1];

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    red_div  = CW'(MODULUS << red_cnt);
    red_next = (red_val >= red_div) ? red_val - red_div : red_val;
    commit   = (state == ST_REDUCE) && (red_cnt == '0);

    emit_fire = (state == ST_EMIT) && out_free;
    at_end    = (n == total - NW'(1));

    ctl.clear    = in_xfer && (kind == KIND_MULTIPLY);
    ctl.step     = (state == ST_MUL);
    ctl.first    = (bit_cnt == BCW'(CW - 1));
    ctl.bit_val  = x[CW-1];
    ctl.accum    = (state == ST_ACC);
    ctl.use_prod = (n < NW'(first_length));
  end

  always_ff @(posedge clk) begin
    if (commit && !red_to_b) begin
      a_store[first_length[AW-1:0]] <= red_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_length  <= '0;
      second_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (kind)
              KIND_FIRST: begin
                if (first_length < LW'(MAX_LEN)) begin
                  red_val  <= coefficient;
                  red_to_b <= 1'b0;
                  red_cnt  <= RCW'(RED_STEPS - 1);
                  state    <= ST_REDUCE;
                end
              end
              KIND_SECOND: begin
                if (second_length < LW'(MAX_LEN)) begin
                  red_val  <= coefficient;
                  red_to_b <= 1'b1;
                  red_cnt  <= RCW'(RED_STEPS - 1);
                  state    <= ST_REDUCE;
                end
              end
              KIND_MULTIPLY: begin
                if (first_length != '0 && second_length != '0) begin
                  total <= NW'(first_length) + NW'(second_length) - NW'(1);
                  n     <= '0;
                  state <= ST_FETCH;
                end else begin
                  first_length  <= '0;
                  second_length <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_REDUCE: begin
          red_val <= red_next;
          if (red_cnt == '0) begin
            if (red_to_b) begin
              second_length <= second_length + LW'(1);
            end else begin
              first_length <= first_length + LW'(1);
            end
            state <= ST_IDLE;
          end else begin
            red_cnt <= red_cnt - RCW'(1);
          end
        end
        ST_FETCH: begin
          // past the first factor the input stream is zero: skip the multiply
          if (n < NW'(first_length)) begin
            x       <= a_store[n[AW-1:0]];
            bit_cnt <= BCW'(CW - 1);
            state   <= ST_MUL;
          end else begin
            state <= ST_ACC;
          end
        end
        ST_MUL: begin
          x <= x << 1;
          if (bit_cnt == '0) begin
            state <= ST_ACC;
          end else begin
            bit_cnt <= bit_cnt - BCW'(1);
          end
        end
        ST_ACC: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            product_coefficient <= s_chain[0];
            last                <= at_end;
            if (at_end) begin
              first_length  <= '0;
              second_length <= '0;
              state         <= ST_IDLE;
            end else begin
              n     <= n + NW'(1);
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_chain[MAX_LEN] = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    mpm_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load       (commit && red_to_b && (second_length == LW'(j))),
      .active     (LW'(j) < second_length),
      .load_value (red_next),
      .s_in       (s_chain[j+1]),
      .s_out      (s_chain[j])
    );
  end

endmodule
